// ===== rtl/dsdate_pkg.sv =====
// Package for the day serial to date converter.
// Holds shared widths, calendar constants, the controller/datapath
// interface structs and the calendar helper functions. No dependencies.
`timescale 1ns / 1ps

package dsdate_pkg;

  localparam int SerialW    = 17;
  localparam int OffsetW    = 8;
  localparam int YearW      = 12;
  localparam int MonthW     = 4;
  localparam int DayW       = 5;
  localparam int YearLenW   = 9;
  localparam int MonthLenW  = 5;

  localparam logic [YearW-1:0]     FirstYear  = 12'd1900;
  localparam logic [OffsetW-1:0]   LastOffset = 8'd199;
  localparam logic [SerialW-1:0]   LastSerial = 17'd73049;
  localparam logic [MonthW-1:0]    LastMonth  = 4'd12;
  localparam logic [MonthW-1:0]    FirstMonth = 4'd1;
  localparam logic [DayW-1:0]      MaxDay     = 5'd31;
  localparam logic [MonthLenW-1:0] BaseMonth  = 5'd28;
  localparam logic [YearLenW-1:0]  BaseYear   = 9'd365;

  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
    logic out_load;
  } dsdate_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } dsdate_status_t;

  // The first year is divisible by 4 but not by 400, and the last offset
  // stops short of the next century, so only the first year breaks the
  // plain rule of four in this range.
  function automatic logic leap_offset(input logic [OffsetW-1:0] off);
    return (off[1:0] == 2'b00) && (off != '0);
  endfunction

  function automatic logic [MonthLenW-1:0] month_length(input logic [MonthW-1:0] m,
                                                        input logic leap);
    logic [MonthLenW-1:0] len;
    len = BaseMonth;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = BaseMonth + 5'd3;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = BaseMonth + 5'd2;
      default:                                    len = BaseMonth + {4'd0, leap};
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/day_serial_to_date.sv =====
// Day serial to Gregorian date converter, top level.
// Serial 1 is 1900-01-01. The input channel (in_valid_i / in_stall_o) carries
// a signed 32-bit serial in day_number_i; one transfer happens at a rising
// edge with valid high and stall low. The output channel (out_valid_o /
// out_stall_i) returns year_o, month_o and day_o for each input.
// Serials at or below zero give 1900-01-01, serials past 2099-12-31 give
// that date.
// Sequence: from the accepting edge the controller walks whole years (up to
// 199), sees the year walk end, walks months (up to 11), then writes the
// output register and raises out_valid_o; it waits in the month state while
// the output register is not free. The next input can transfer once the
// controller is back in idle.
// One conversion is in flight at a time; in_stall_o is high from the
// accepting edge until the result is written to the output register.
// A finished result waits in the output register while out_stall_i is high;
// the next input may be accepted meanwhile, and its result waits in the
// walk registers until the output register frees.
// Reset clears the controller and output valid; no result is pending after.
`timescale 1ns / 1ps

module day_serial_to_date import dsdate_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  day_number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [YearW-1:0]    year_o,
  output logic [MonthW-1:0]   month_o,
  output logic [DayW-1:0]     day_o
);

  dsdate_cmd_t    cmd;
  dsdate_status_t status;

  dsdate_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dsdate_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .day_number_i (day_number_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .year_o       (year_o),
    .month_o      (month_o),
    .day_o        (day_o)
  );

endmodule

// ===== rtl/dsdate_dp.sv =====
// Datapath of the day serial to date converter: clamp, year and month
// walk registers, and the output payload registers.
// Depends on dsdate_pkg.
`timescale 1ns / 1ps

module dsdate_dp import dsdate_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic signed [31:0]   day_number_i,
  input  dsdate_cmd_t          cmd_i,
  output dsdate_status_t       status_o,
  output logic [YearW-1:0]     year_o,
  output logic [MonthW-1:0]    month_o,
  output logic [DayW-1:0]      day_o
);

  logic [SerialW-1:0]   rem_q, rem_d;
  logic [OffsetW-1:0]   off_q, off_d;
  logic [MonthW-1:0]    mon_q, mon_d;
  logic [YearW-1:0]     year_q;
  logic [MonthW-1:0]    month_q;
  logic [DayW-1:0]      day_q;
  logic [SerialW-1:0]   clamped;
  logic                 leap;
  logic [YearLenW-1:0]  year_len;
  logic [MonthLenW-1:0] mon_len;
  logic [DayW-1:0]      day_sat;

  always_comb begin
    priority if (day_number_i[31] || day_number_i == 32'sd0) begin
      clamped = SerialW'(1);
    end else if (day_number_i > $signed({15'd0, LastSerial})) begin
      clamped = LastSerial;
    end else begin
      clamped = day_number_i[SerialW-1:0];
    end
  end

  assign leap     = leap_offset(off_q);
  assign year_len = BaseYear + {8'd0, leap};
  assign mon_len  = month_length(mon_q, leap);

  assign status_o.year_done  = (rem_q <= {8'd0, year_len}) || (off_q >= LastOffset);
  assign status_o.month_done = (rem_q <= {12'd0, mon_len}) || (mon_q >= LastMonth);

  always_comb begin
    rem_d = rem_q;
    off_d = off_q;
    mon_d = mon_q;
    priority if (cmd_i.load) begin
      rem_d = clamped;
      off_d = '0;
      mon_d = FirstMonth;
    end else if (cmd_i.year_step) begin
      rem_d = rem_q - {8'd0, year_len};
      off_d = off_q + 8'd1;
    end else if (cmd_i.month_step) begin
      rem_d = rem_q - {12'd0, mon_len};
      mon_d = mon_q + 4'd1;
    end else begin
      rem_d = rem_q;
    end
  end

  always_comb begin
    priority if (rem_q == '0) begin
      day_sat = DayW'(1);
    end else if (rem_q > {12'd0, MaxDay}) begin
      day_sat = MaxDay;
    end else begin
      day_sat = rem_q[DayW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      off_q   <= '0;
      mon_q   <= FirstMonth;
      year_q  <= FirstYear;
      month_q <= FirstMonth;
      day_q   <= DayW'(1);
    end else begin
      rem_q <= rem_d;
      off_q <= off_d;
      mon_q <= mon_d;
      if (cmd_i.out_load) begin
        year_q  <= FirstYear + {4'd0, off_q};
        month_q <= mon_q;
        day_q   <= day_sat;
      end
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

// ===== rtl/dsdate_ctrl.sv =====
// Controller of the day serial to date converter: sequences the year and
// month walks and owns the input stall and output valid.
// Depends on dsdate_pkg.
`timescale 1ns / 1ps

module dsdate_ctrl import dsdate_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  dsdate_status_t status_i,
  output dsdate_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StYear  = 2'd1;
  localparam logic [1:0] StMonth = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new result when empty or when its
  // current result transfers in this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StYear;
        end
      end
      StYear: begin
        if (status_i.year_done) begin
          state_d = StMonth;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      StMonth: begin
        if (!status_i.month_done) begin
          cmd_o.month_step = 1'b1;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for day_serial_to_date.
// Day serials go in through a queue-fed driver, and a monitor checks each date against
// a calendar predictor kept here. Depends on dsdate_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
  import dsdate_pkg::*;

  localparam int FirstCalYear   = 1900;
  localparam int LastCalYear    = 2099;
  localparam int LastDaySerial  = 73049;
  localparam int RandomSerials  = 1450;
  localparam int DrainCycles    = 240;
  localparam int CalmStart      = 30000;
  localparam int CalmEnd        = 60000;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } calendar_date_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic signed [31:0]  day_number_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [YearW-1:0]    year_o;
  logic [MonthW-1:0]   month_o;
  logic [DayW-1:0]     day_o;

  logic signed [31:0] pending_serials[$];
  calendar_date_t     expected_dates[$];
  logic               took_serial = 1'b0;
  int                 cycle_count = 0;
  int                 mismatch_count = 0;
  int                 dates_checked = 0;
  int                 clamped_low = 0;
  int                 clamped_high = 0;
  int                 leap_days_seen = 0;

  day_serial_to_date uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .day_number_i (day_number_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .year_o       (year_o),
    .month_o      (month_o),
    .day_o        (day_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_leap(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int year_days(int y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic int days_in_month(int y, int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      default:               return is_leap(y) ? 29 : 28;
    endcase
  endfunction

  // Serial of the day before January 1st of year y.
  function automatic int days_before_year(int y);
    int total;
    total = 0;
    for (int yy = FirstCalYear; yy < y; yy++) total += year_days(yy);
    return total;
  endfunction

  function automatic calendar_date_t civil_date(int serial);
    int rem;
    int yr;
    int mo;
    calendar_date_t d;
    rem = (serial < 1) ? 1 : ((serial > LastDaySerial) ? LastDaySerial : serial);
    yr = FirstCalYear;
    while (yr < LastCalYear && rem > year_days(yr)) begin
      rem -= year_days(yr);
      yr++;
    end
    mo = 1;
    while (mo < 12 && rem > days_in_month(yr, mo)) begin
      rem -= days_in_month(yr, mo);
      mo++;
    end
    d.year  = yr[YearW-1:0];
    d.month = mo[MonthW-1:0];
    d.day   = rem[DayW-1:0];
    return d;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // No random idling on either side inside the calm window.
  function automatic bit random_pause();
    if (cycle_count >= CalmStart && cycle_count < CalmEnd) return 1'b0;
    return $urandom_range(0, 99) < 19;
  endfunction

  // A new serial is presented only once the previous one was transferred.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || took_serial) begin
        if (pending_serials.size() != 0 && !random_pause()) begin
          in_valid_i   <= 1'b1;
          day_number_i <= pending_serials.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= random_pause();
    end
  end

  always @(posedge clk_i) begin
    calendar_date_t want;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      took_serial <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("unexpected date %0d-%0d-%0d", year_o, month_o, day_o));
        end else begin
          want = expected_dates.pop_front();
          dates_checked++;
          if (year_o !== want.year)
            report_mismatch($sformatf("year %0d, expected %0d", year_o, want.year));
          if (month_o !== want.month)
            report_mismatch($sformatf("month %0d, expected %0d", month_o, want.month));
          if (day_o !== want.day)
            report_mismatch($sformatf("day %0d, expected %0d", day_o, want.day));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = civil_date(day_number_i);
        expected_dates.push_back(want);
        if (day_number_i < 1) clamped_low++;
        if (day_number_i > LastDaySerial) clamped_high++;
        if (want.month == 4'd2 && want.day == 5'd29) leap_days_seen++;
      end
    end
  end

  initial begin
    int y;
    int s;
    // Edges of the range, the non-leap 1900, ordinary and century leap days.
    int directed[$] = '{32'sh8000_0000, -1, 0, 1, 2, 31, 32, 59, 60, 365, 366,
                        1461, 1520, 1521, 1826, 1827, 36525, 36584, 36585,
                        73048, 73049, 73050, 32'sh7fff_ffff, 32'sh5555_5555,
                        32'shaaaa_aaaa};
    foreach (directed[i]) pending_serials.push_back(directed[i]);
    for (int n = 0; n < RandomSerials; n++) begin
      case ($urandom_range(0, 19))
        12, 13:  s = $urandom();
        14:      s = -$urandom_range(0, 1000);
        15:      s = $urandom_range(LastDaySerial - 40, LastDaySerial + 40);
        16: begin
          y = $urandom_range(FirstCalYear, LastCalYear);
          s = days_before_year(y) + 1 + $urandom_range(0, 4) - 2;
        end
        17: begin
          y = $urandom_range(FirstCalYear, LastCalYear);
          s = days_before_year(y) + $urandom_range(58, 61);
        end
        default: s = $urandom_range(1, LastDaySerial);
      endcase
      pending_serials.push_back(s);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_serials.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_dates.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (expected_dates.size() != 0)
      report_mismatch($sformatf("%0d dates never arrived", expected_dates.size()));

    $display("Checked %0d conversions: %0d serials clamped low, %0d clamped high,",
             dates_checked, clamped_low, clamped_high);
    $display("%0d landing on February 29th, %0d mismatches.", leap_days_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d dates outstanding.", expected_dates.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
